/* rtl/core/prrfq_pkg.sv */
// ----------------------------------------------------------------------------
// prrfq_pkg
// Shared types, codes and default sizes for the priority round-robin flow
// queue.
// ----------------------------------------------------------------------------
package prrfq_pkg;

	localparam int NUM_PRIORITIES = 4;
	localparam int NUM_FLOWS      = 16;
	localparam int QUEUE_DEPTH    = 8;
	localparam int TAG_BITS       = 16;

	// widest indexes the picker can report (parameter ranges)
	localparam int FLOW_IDX_MAX_BITS = 8;
	localparam int LVL_IDX_MAX_BITS  = 4;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  flow;
		logic [1:0]  priority_req;
		logic [15:0] packet_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_tag;
		logic [3:0]  out_flow;
		logic [1:0]  out_priority;
		logic [3:0]  flushed_count;
		logic [9:0]  total_count;
	} rsp_t;

	typedef struct packed {
		logic                         found;
		logic [FLOW_IDX_MAX_BITS-1:0] flow;
		logic [LVL_IDX_MAX_BITS-1:0]  level;
	} pick_t;

endpackage

/* rtl/core/prrfq_meta_ram.sv */
// ----------------------------------------------------------------------------
// prrfq_meta_ram
// Per-queue head and fill memory with a registered read, and with a valid
// bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module prrfq_meta_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    data_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

/* rtl/core/prrfq_tag_ram.sv */
// ----------------------------------------------------------------------------
// prrfq_tag_ram
// Packet tag store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prrfq_tag_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int TW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [TW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [TW-1:0] wr_data
);

	logic [TW-1:0] mem [DEPTH];
	logic [TW-1:0] data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	assign rd_data = data_q;

endmodule

/* rtl/core/prrfq_pick.sv */
// ----------------------------------------------------------------------------
// prrfq_pick
// Dequeue selection: lowest busy level, then the first non-empty flow at or
// after that level's round-robin pointer, wrapping.
// ----------------------------------------------------------------------------
module prrfq_pick #(
	parameter int NP = 4,
	parameter int NF = 16,
	parameter int PW = 2,
	parameter int FW = 4
) (
	input  logic [NP*NF-1:0]    nonempty,
	input  logic [NP-1:0]       level_busy,
	input  logic [NP*(FW+1)-1:0] rr_ptr,
	output prrfq_pkg::pick_t    pick
);

	logic          lvl_hit;
	logic [PW-1:0] lvl;
	logic [NF-1:0] row;
	logic [FW:0]   ptr;
	logic [FW-1:0] start;
	logic          hit_hi;
	logic          hit_lo;
	logic [FW-1:0] f_hi;
	logic [FW-1:0] f_lo;

	always_comb begin
		lvl_hit = 1'b0;
		lvl     = '0;
		for (int l = 0; l < NP; l++) begin
			if (!lvl_hit && level_busy[l]) begin
				lvl_hit = 1'b1;
				lvl     = PW'(l);
			end
		end
		row   = nonempty[lvl*NF +: NF];
		ptr   = rr_ptr[lvl*(FW+1) +: (FW+1)];
		start = (ptr >= (FW+1)'(NF)) ? '0 : ptr[FW-1:0];
		hit_hi = 1'b0;
		hit_lo = 1'b0;
		f_hi   = '0;
		f_lo   = '0;
		for (int f = 0; f < NF; f++) begin
			if (!hit_hi && row[f] && (f >= int'(start))) begin
				hit_hi = 1'b1;
				f_hi   = FW'(f);
			end
			if (!hit_lo && row[f]) begin
				hit_lo = 1'b1;
				f_lo   = FW'(f);
			end
		end
		pick.found = lvl_hit && hit_lo;
		pick.flow  = prrfq_pkg::FLOW_IDX_MAX_BITS'(hit_hi ? f_hi : f_lo);
		pick.level = prrfq_pkg::LVL_IDX_MAX_BITS'(lvl);
	end

endmodule

/* rtl/core/priority_round_robin_flow_queue.sv */
// ----------------------------------------------------------------------------
// priority_round_robin_flow_queue
// Strict-priority round-robin scheduler over per-flow tag FIFOs.
// ----------------------------------------------------------------------------
// Sequence: an accepted request reads the head/fill memory, then in S_META
//   reads the tag memory for a dequeue (writes it for an enqueue), and in
//   S_OUT loads the response. A new request is taken only in S_IDLE, after
//   the last one has loaded its response, while that response may still wait for rsp_ready.
// Reset: arst_n clears all queues and level counts and resets the pointers
//   at once; the tag memory needs no clearing.
module priority_round_robin_flow_queue #(
	parameter int NUM_PRIORITIES = prrfq_pkg::NUM_PRIORITIES,
	parameter int NUM_FLOWS      = prrfq_pkg::NUM_FLOWS,
	parameter int QUEUE_DEPTH    = prrfq_pkg::QUEUE_DEPTH,
	parameter int TAG_BITS       = prrfq_pkg::TAG_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  prrfq_pkg::req_t  req_data,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output prrfq_pkg::rsp_t  rsp_data
);

	localparam int NP    = NUM_PRIORITIES;
	localparam int NF    = NUM_FLOWS;
	localparam int QD    = QUEUE_DEPTH;
	localparam int PW    = (NP > 1) ? $clog2(NP) : 1;
	localparam int FW    = $clog2(NF);
	localparam int HW    = $clog2(QD);
	localparam int CW    = $clog2(QD + 1);
	localparam int PAIRS = NP * NF;
	localparam int PAW   = $clog2(PAIRS);
	localparam int TAW   = $clog2(PAIRS * QD);
	localparam int LCW   = $clog2(NF * QD + 1);
	localparam int TOTW  = $clog2(NP * NF * QD + 1);
	localparam int MW    = HW + CW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_META = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]            state_q;
	prrfq_pkg::req_t       req_q;
	logic                  in_range_q;
	logic [PAW-1:0]        pair_q;
	logic [FW-1:0]         pflow_q;
	logic [PW-1:0]         plvl_q;
	logic                  found_q;
	logic [PAIRS-1:0]      nonempty_q;
	logic [LCW-1:0]        lvl_cnt_q [NP];
	logic [FW:0]           rr_q [NP];
	logic [TOTW-1:0]       total_q;
	prrfq_pkg::rsp_t       res_q;
	logic                  deq_q;
	prrfq_pkg::rsp_t       rsp_q;
	logic                  rsp_valid_q;

	logic                  accept;
	logic [NP-1:0]         level_busy;
	logic [NP*(FW+1)-1:0]  rr_flat;
	prrfq_pkg::pick_t      pick;
	logic                  in_range_d;
	logic [FW-1:0]         rflow;
	logic [PW-1:0]         rlvl;
	logic [PAW-1:0]        pair_d;
	prrfq_pkg::rsp_t       res_d;
	prrfq_pkg::rsp_t       rsp_d;

	logic [MW-1:0]         meta_rd;
	logic [HW-1:0]         head_m;
	logic [CW-1:0]         fill_m;
	logic                  meta_we;
	logic [MW-1:0]         meta_wd;
	logic                  tag_we;
	logic                  tag_re;
	logic [TAW-1:0]        tag_addr_rd;
	logic [TAW-1:0]        tag_addr_wr;
	logic [TAG_BITS-1:0]   tag_rd;
	logic [HW:0]           slot_sum;
	logic [HW-1:0]         slot;
	logic [HW:0]           head_inc;
	logic [HW-1:0]         head_nxt;
	logic                  out_load;

	// ---------------------------------------------------------------- request
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	assign in_range_d = (int'(req_data.flow) < NF) && (int'(req_data.priority_req) < NP);
	assign rflow      = FW'(req_data.flow);
	assign rlvl       = PW'(req_data.priority_req);

	always_comb begin
		for (int l = 0; l < NP; l++) begin
			level_busy[l]            = (lvl_cnt_q[l] != '0);
			rr_flat[l*(FW+1) +: FW+1] = rr_q[l];
		end
	end

	prrfq_pick #(
		.NP (NP),
		.NF (NF),
		.PW (PW),
		.FW (FW)
	) u_pick (
		.nonempty   (nonempty_q),
		.level_busy (level_busy),
		.rr_ptr     (rr_flat),
		.pick       (pick)
	);

	// dequeue addresses the picked queue; the others the requested one
	always_comb begin
		if (req_data.operation == prrfq_pkg::OP_DEQUEUE) begin
			pair_d = PAW'(int'(PW'(pick.level)) * NF + int'(FW'(pick.flow)));
		end else begin
			pair_d = PAW'(int'(rlvl) * NF + int'(rflow));
		end
	end

	// ---------------------------------------------------------------- memories
	prrfq_meta_ram #(
		.DEPTH (PAIRS),
		.AW    (PAW),
		.DW    (MW)
	) u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pair_d),
		.rd_data (meta_rd),
		.wr_en   (meta_we),
		.wr_addr (pair_q),
		.wr_data (meta_wd)
	);

	assign head_m = meta_rd[MW-1 -: HW];
	assign fill_m = meta_rd[CW-1:0];

	// wrap the write slot and the advanced head without a divider
	assign slot_sum = (HW+1)'(head_m) + (HW+1)'(fill_m);
	assign slot     = (slot_sum >= (HW+1)'(QD)) ? HW'(slot_sum - (HW+1)'(QD))
		: HW'(slot_sum);
	assign head_inc = (HW+1)'(head_m) + 1'b1;
	assign head_nxt = (head_inc >= (HW+1)'(QD)) ? '0 : HW'(head_inc);

	assign tag_addr_wr = TAW'(int'(pair_q) * QD + int'(slot));
	assign tag_addr_rd = TAW'(int'(pair_q) * QD + int'(head_m));

	prrfq_tag_ram #(
		.DEPTH (PAIRS * QD),
		.AW    (TAW),
		.TW    (TAG_BITS)
	) u_tag (
		.clk     (clk),
		.rd_en   (tag_re),
		.rd_addr (tag_addr_rd),
		.rd_data (tag_rd),
		.wr_en   (tag_we),
		.wr_addr (tag_addr_wr),
		.wr_data (TAG_BITS'(req_q.packet_tag))
	);

	// ---------------------------------------------------------------- update
	logic enq_ok;
	logic enq_full;
	logic deq_ok;
	logic flush_ok;

	assign enq_ok   = (state_q == S_META) && (req_q.operation == prrfq_pkg::OP_ENQUEUE)
		&& in_range_q && (fill_m < CW'(QD));
	assign enq_full = (req_q.operation == prrfq_pkg::OP_ENQUEUE) && !enq_ok;
	assign deq_ok   = (state_q == S_META) && (req_q.operation == prrfq_pkg::OP_DEQUEUE)
		&& found_q;
	assign flush_ok = (state_q == S_META) && (req_q.operation == prrfq_pkg::OP_FLUSH)
		&& in_range_q;

	assign tag_we  = enq_ok;
	assign tag_re  = deq_ok;
	assign meta_we = enq_ok || deq_ok || flush_ok;

	always_comb begin
		meta_wd = '0;
		if (enq_ok) begin
			meta_wd = {head_m, CW'(fill_m + 1'b1)};
		end else if (deq_ok) begin
			meta_wd = {head_nxt, CW'(fill_m - 1'b1)};
		end
	end

	// build the response fields known once the head/fill read is back
	always_comb begin
		res_d = '0;
		if (enq_ok) begin
			res_d.total_count = 10'(total_q + 1'b1);
		end else if (deq_ok) begin
			res_d.out_flow     = 4'(pflow_q);
			res_d.out_priority = 2'(plvl_q);
			res_d.total_count  = 10'(total_q - 1'b1);
		end else if (flush_ok) begin
			res_d.flushed_count = 4'(fill_m);
			res_d.total_count   = 10'(total_q - TOTW'(fill_m));
		end else begin
			res_d.total_count = 10'(total_q);
			if (enq_full) begin
				res_d.status = prrfq_pkg::STAT_FULL;
			end else if (req_q.operation == prrfq_pkg::OP_DEQUEUE) begin
				res_d.status = prrfq_pkg::STAT_EMPTY;
			end
		end
	end

	// merge the dequeued tag once the tag memory read is back
	always_comb begin
		rsp_d         = res_q;
		rsp_d.out_tag = deq_q ? 16'(tag_rd) : '0;
	end

	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req_data;
			in_range_q <= in_range_d;
			pair_q     <= pair_d;
			pflow_q    <= FW'(pick.flow);
			plvl_q     <= PW'(pick.level);
			found_q    <= pick.found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			total_q     <= '0;
			deq_q       <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int l = 0; l < NP; l++) begin
				lvl_cnt_q[l] <= '0;
				rr_q[l]      <= (FW+1)'(NF);
			end
		end else begin
			// raise on a new response, drop the held response once taken
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_META;
					end
				end
				S_META: begin
					res_q   <= res_d;
					deq_q   <= deq_ok;
					state_q <= S_OUT;
					if (enq_ok) begin
						nonempty_q[pair_q]          <= 1'b1;
						lvl_cnt_q[PW'(req_q.priority_req)] <=
							lvl_cnt_q[PW'(req_q.priority_req)] + 1'b1;
						total_q                     <= total_q + 1'b1;
					end else if (deq_ok) begin
						nonempty_q[pair_q]  <= (fill_m != CW'(1));
						lvl_cnt_q[plvl_q]   <= lvl_cnt_q[plvl_q] - 1'b1;
						rr_q[plvl_q]        <= (FW+1)'(pflow_q) + 1'b1;
						total_q             <= total_q - 1'b1;
					end else if (flush_ok) begin
						nonempty_q[pair_q]  <= 1'b0;
						lvl_cnt_q[PW'(req_q.priority_req)] <=
							lvl_cnt_q[PW'(req_q.priority_req)] - LCW'(fill_m);
						total_q             <= total_q - TOTW'(fill_m);
					end
				end
				S_OUT: begin
					// hold here until the response register frees up
					if (out_load) begin
						rsp_q   <= rsp_d;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* rtl/core/prrfq_checker.sv */
// ----------------------------------------------------------------------------
// prrfq_checker
// Port-level checks for the priority round-robin flow queue.
// ----------------------------------------------------------------------------
module prrfq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input prrfq_pkg::req_t req_data,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input prrfq_pkg::rsp_t rsp_data
);

	// one request in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");

	// an empty dequeue must report nothing held
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status == prrfq_pkg::STAT_EMPTY)
		|-> (rsp_data.total_count == 10'd0))
		else $error("empty status with packets held");

	// a response never carries an unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == prrfq_pkg::STAT_OK
			|| rsp_data.status == prrfq_pkg::STAT_EMPTY
			|| rsp_data.status == prrfq_pkg::STAT_FULL))
		else $error("bad status code");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled response changed");

endmodule

bind priority_round_robin_flow_queue prrfq_checker u_prrfq_checker (.*);
